### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a clocked property, held off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

### hw/rtl/mnpt_pkg.sv
// Types, constants and helper functions of the MIDI note pulse trigger.
package mnpt_pkg;

  localparam int unsigned CHANNELS = 6;
  localparam int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DRIVE_W  = 6;
  localparam int unsigned SLOT_W   = 3;

  localparam int unsigned BASE_W   = 12;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned CFG_D_W  = 16;

  localparam logic [3:0]        PROG_CHANNEL    = 4'd15;
  localparam logic [NOTE_W-1:0] CTL_MODE        = 7'd119;
  localparam logic [NOTE_W-1:0] CTL_TABLE_FIRST = 7'd110;
  localparam logic [NOTE_W-1:0] MODE_WRITE      = 7'd1;
  localparam logic [NOTE_W-1:0] READ_ACK_VALUE  = 7'd1;

  localparam logic [BASE_W-1:0] BASE_RESET = 12'd10;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

  // Input item kinds
  typedef enum logic [1:0] {
    CMD_NOTE_ON = 2'd0,
    CMD_CTL     = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IX_W-1:0] {
    REG_PULSE_BASE = 2'd0,
    REG_PULSE_STEP = 2'd1,
    REG_LED_HOLD   = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  // Operation of the shared channel unit for one step
  typedef enum logic [1:0] {
    OP_NOTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_TWRITE = 2'd2,
    OP_TREAD  = 2'd3
  } op_kind_t;

  // What the result beats of an item look like
  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_SAVE  = 2'd1,
    RES_READ  = 2'd2,
    RES_RSVD  = 2'd3
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EMIT_A = 4'b0100,
    S_EMIT_B = 4'b1000
  } state_t;

  // Command from the sequencer to the channel unit
  typedef struct packed {
    logic              step;
    op_kind_t          kind;
    logic [IDX_W-1:0]  idx;
    logic [NOTE_W-1:0] key;
    logic [CNT_W-1:0]  load;
  } chan_op_t;

  // Status back from the channel unit
  typedef struct packed {
    logic              hit;
    logic [NOTE_W-1:0] note;
  } chan_stat_t;

  function automatic logic [NOTE_W-1:0] default_note(input int unsigned i);
    logic [NOTE_W-1:0] n;
    unique case (i)
      0:       n = 7'd60;
      1:       n = 7'd62;
      2:       n = 7'd64;
      3:       n = 7'd67;
      4:       n = 7'd69;
      5:       n = 7'd72;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

### hw/rtl/mnpt_chan_unit.sv
// Note table, pulse counters and drive levels, one channel handled per step.
module mnpt_chan_unit
  import mnpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  chan_op_t            op,
  output chan_stat_t          stat,
  output logic [CHANNELS-1:0] drive
);

  logic [NOTE_W-1:0]   tbl_r [CHANNELS];
  logic [CNT_W-1:0]    cnt_r [CHANNELS];
  logic [CHANNELS-1:0] drive_r;

  logic [NOTE_W-1:0] note_rd;
  logic [CNT_W-1:0]  cnt_rd;

  // Shared compare and decrement work on the addressed channel only
  assign note_rd   = tbl_r[op.idx];
  assign cnt_rd    = cnt_r[op.idx];
  assign stat.hit  = (note_rd == op.key);
  assign stat.note = note_rd;
  assign drive     = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        tbl_r[i] <= default_note(i);
        cnt_r[i] <= '0;
      end
      drive_r <= '0;
    end else if (op.step) begin
      unique case (op.kind)
        OP_NOTE: begin
          if (stat.hit) begin
            cnt_r[op.idx]   <= op.load;
            drive_r[op.idx] <= 1'b1;
          end
        end
        OP_TICK: begin
          if (cnt_rd != '0) begin
            cnt_r[op.idx] <= cnt_rd - CNT_W'(1);
            if (cnt_rd == CNT_W'(1)) begin
              drive_r[op.idx] <= 1'b0;
            end
          end
        end
        OP_TWRITE: begin
          tbl_r[op.idx] <= op.key;
        end
        OP_TREAD: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/midi_note_pulse_trigger.sv
// Top level of the MIDI note pulse trigger: sequencer, LED, mode and output register.
//
// Usage
//   Input channel (in_*): one beat per MIDI event or tick. in_cmd 0 is a note-on,
//   1 a control change, 2 a tick; 3 changes nothing and still gives one beat.
//   Result channel (out_*): one beat per input beat, two for a note table read
//   (control change on channel 15, controllers 110..115, mode other than 1).
//   out_last marks the final beat of an input. Every beat shows the drive and LED
//   levels as they stand after that input.
//   Configuration port (cfg_*): write pulse_base, pulse_step and led_hold while
//   the block is idle; writes take effect at once, indexes past the list are dropped.
// Timing
//   A single shared compare/decrement unit walks the channels one per cycle.
//   Tick: all CHANNELS are scanned. Note-on with a nonzero amount: entries are
//   scanned up to the first match (all CHANNELS when none matches). Table access:
//   a single step on the addressed entry. Other items: no scan. The output register
//   is then loaded; a table read loads its second beat before the return to idle.
// Reset and stall
//   Reset restores the default note table and register values and clears all
//   counters, drive and LED levels, out_valid and the mode. On a receiver stall,
//   the output register holds its beat; the next input is taken, its first beat waits.
module midi_note_pulse_trigger
  import mnpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [3:0]          in_midi_channel,
  input  logic [NOTE_W-1:0]   in_number,
  input  logic [NOTE_W-1:0]   in_amount,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [DRIVE_W-1:0]  out_drive,
  output logic                out_led,
  output logic                out_reply_valid,
  output logic [NOTE_W-1:0]   out_reply_controller,
  output logic [NOTE_W-1:0]   out_reply_value,
  output logic                out_save_valid,
  output logic [SLOT_W-1:0]   out_save_slot,
  output logic [NOTE_W-1:0]   out_save_value,
  output logic                out_last,

  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_wdata
);

  `include "assert_macros.svh"

  // Configuration registers
  logic [BASE_W-1:0] base_r;
  logic [STEP_W-1:0] step_r;
  logic [HOLD_W-1:0] hold_r;

  // Sequencer and item context
  state_t            state_r, state_nxt;
  op_kind_t          op_r, op_nxt;
  res_kind_t         res_r, res_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [NOTE_W-1:0] num_r;
  logic [NOTE_W-1:0] key_r;
  logic [CNT_W-1:0]  load_r;
  logic [NOTE_W-1:0] rval_r;

  // LED and programming mode
  logic [HOLD_W-1:0] led_cnt_r, led_cnt_nxt;
  logic              led_r, led_nxt;
  logic [NOTE_W-1:0] mode_r, mode_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] o_drive_r;
  logic              o_led_r;
  logic              o_rv_r;
  logic [NOTE_W-1:0] o_rc_r;
  logic [NOTE_W-1:0] o_rval_r;
  logic              o_sv_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [NOTE_W-1:0] o_sval_r;
  logic              o_last_r;

  logic              in_fire;
  logic              out_free;
  logic              beat_load;
  logic              beat_b;
  logic              scan_end;
  logic [NOTE_W-1:0] num_off;
  logic              in_tbl;
  logic [CNT_W-1:0]  pulse_len;
  chan_op_t          cop;
  chan_stat_t        cstat;
  logic [CHANNELS-1:0] drive;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Pulse length: one narrow multiply and add, registered at accept
  assign pulse_len = CNT_W'(base_r) + CNT_W'(step_r * in_amount);

  // Table controllers sit at 110 .. 110+CHANNELS-1
  assign num_off = in_number - CTL_TABLE_FIRST;
  assign in_tbl  = (in_number >= CTL_TABLE_FIRST) && (num_off < NOTE_W'(CHANNELS));

  assign cop.step = (state_r == S_SCAN);
  assign cop.kind = op_r;
  assign cop.idx  = idx_r;
  assign cop.key  = key_r;
  assign cop.load = load_r;

  mnpt_chan_unit u_chan (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (cop),
    .stat  (cstat),
    .drive (drive)
  );

  // Stop the walk on the last channel, on the first note match, or after a table step
  always_comb begin
    scan_end = (idx_r == IDX_W'(CHANNELS - 1));
    if (op_r == OP_TWRITE || op_r == OP_TREAD) begin
      scan_end = 1'b1;
    end else if (op_r == OP_NOTE && cstat.hit) begin
      scan_end = 1'b1;
    end
  end

  // Sequencer, LED and mode: item decode happens on the accept edge
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    res_nxt     = res_r;
    idx_nxt     = idx_r;
    led_cnt_nxt = led_cnt_r;
    led_nxt     = led_r;
    mode_nxt    = mode_r;
    beat_load   = 1'b0;
    beat_b      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EMIT_A;
          res_nxt   = RES_PLAIN;
          idx_nxt   = '0;
          unique case (cmd_t'(in_cmd))
            CMD_NOTE_ON: begin
              led_cnt_nxt = hold_r;
              led_nxt     = 1'b1;
              if (in_amount != '0) begin
                op_nxt    = OP_NOTE;
                state_nxt = S_SCAN;
              end
            end
            CMD_CTL: begin
              led_cnt_nxt = hold_r;
              led_nxt     = 1'b1;
              if (in_midi_channel == PROG_CHANNEL) begin
                if (in_number == CTL_MODE) begin
                  mode_nxt = in_amount;
                end else if (in_tbl) begin
                  idx_nxt   = num_off[IDX_W-1:0];
                  state_nxt = S_SCAN;
                  mode_nxt  = '0;
                  if (mode_r == MODE_WRITE) begin
                    op_nxt  = OP_TWRITE;
                    res_nxt = RES_SAVE;
                  end else begin
                    op_nxt  = OP_TREAD;
                    res_nxt = RES_READ;
                  end
                end
              end
            end
            CMD_TICK: begin
              op_nxt    = OP_TICK;
              state_nxt = S_SCAN;
              if (led_cnt_r != '0) begin
                led_cnt_nxt = led_cnt_r - HOLD_W'(1);
                if (led_cnt_r == HOLD_W'(1)) begin
                  led_nxt = 1'b0;
                end
              end
            end
            CMD_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_EMIT_A;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          beat_load = 1'b1;
          state_nxt = (res_r == RES_READ) ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          beat_load = 1'b1;
          beat_b    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (beat_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NOTE;
      res_r       <= RES_PLAIN;
      idx_r       <= '0;
      led_cnt_r   <= '0;
      led_r       <= 1'b0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      step_r      <= STEP_RESET;
      hold_r      <= HOLD_RESET;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      res_r       <= res_nxt;
      idx_r       <= idx_nxt;
      led_cnt_r   <= led_cnt_nxt;
      led_r       <= led_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PULSE_BASE: base_r <= cfg_wdata[BASE_W-1:0];
          REG_PULSE_STEP: step_r <= cfg_wdata[STEP_W-1:0];
          REG_LED_HOLD:   hold_r <= cfg_wdata[HOLD_W-1:0];
          REG_UNUSED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item payload: latch on accept, capture the table read-back in its step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      num_r  <= in_number;
      key_r  <= (cmd_t'(in_cmd) == CMD_NOTE_ON) ? in_number : in_amount;
      load_r <= pulse_len;
    end
    if (state_r == S_SCAN && op_r == OP_TREAD) begin
      rval_r <= cstat.note;
    end
  end

  // Output beat: snapshot of the levels plus reply or save fields
  always_ff @(posedge clk) begin
    if (beat_load) begin
      o_drive_r <= DRIVE_W'(drive);
      o_led_r   <= led_r;
      o_rv_r    <= 1'b0;
      o_rc_r    <= '0;
      o_rval_r  <= '0;
      o_sv_r    <= 1'b0;
      o_slot_r  <= '0;
      o_sval_r  <= '0;
      o_last_r  <= 1'b1;
      if (beat_b) begin
        o_rv_r   <= 1'b1;
        o_rc_r   <= num_r;
        o_rval_r <= rval_r;
      end else begin
        unique case (res_r)
          RES_SAVE: begin
            o_sv_r   <= 1'b1;
            o_slot_r <= SLOT_W'(idx_r);
            o_sval_r <= key_r;
          end
          RES_READ: begin
            o_rv_r   <= 1'b1;
            o_rc_r   <= CTL_MODE;
            o_rval_r <= READ_ACK_VALUE;
            o_last_r <= 1'b0;
          end
          RES_PLAIN: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = o_drive_r;
  assign out_led              = o_led_r;
  assign out_reply_valid      = o_rv_r;
  assign out_reply_controller = o_rc_r;
  assign out_reply_value      = o_rval_r;
  assign out_save_valid       = o_sv_r;
  assign out_save_slot        = o_slot_r;
  assign out_save_value       = o_sval_r;
  assign out_last             = o_last_r;

  // An accepted item keeps the block busy in the following cycle
  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !in_ready, "input taken twice in a row")
  // The first reply beat of a table read is followed straight by the second
  `ASSERT_CLK(a_read_pair, (out_valid && out_ready && !out_last) |=> out_valid,
              "second reply beat missing")
  // A beat never carries a reply and a save request together
  `ASSERT_NEVER(a_reply_save, out_valid && out_reply_valid && out_save_valid,
                "reply and save in one beat")
  // While the channel unit is stepped, the channel index stays in range
  `ASSERT_NEVER(a_scan_idx, cop.step && (idx_r > IDX_W'(CHANNELS - 1)),
                "channel index out of range")

endmodule
